// File: hw/rtl/pad_pkg.sv
// Package for the point angle and distance core.
// Holds item types, fixed-point constants and the CORDIC arctangent table.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package pad_pkg;

   localparam int COORD_WIDTH       = 16;
   localparam int DIFF_WIDTH        = COORD_WIDTH + 1;
   localparam int DEF_CORDIC_STAGES = 16;
   localparam int MAX_CORDIC_STAGES = 24;
   localparam int GUARD_BITS        = 8;
   localparam int XW                = 28;
   localparam int ZW                = 32;
   localparam int ZZW               = 33;
   localparam int GAIN_W            = 32;
   localparam int PW                = (XW - 1) + GAIN_W;
   localparam int ANGLE_W           = 16;
   localparam int DIST_W            = 17;
   localparam int DIST_RAW_W        = PW - 40;
   localparam int TOL_W             = 16;

   localparam logic [TOL_W-1:0]  TOL_RESET   = 16'd160;
   localparam logic [GAIN_W-1:0] INV_GAIN    = 32'd2608131496;
   localparam logic [DIST_W-1:0] DIST_MAX    = 17'h1FFFF;
   localparam logic [ZZW-1:0]    Z_QUARTER   = 33'h040000000;
   localparam logic [PW-1:0]     DIST_ROUND  = PW'(64'h0000_0080_0000_0000);
   localparam logic [ZZW-1:0]    ANGLE_ROUND = 33'h000008000;

   localparam logic [ANGLE_W-1:0] ANG_ZERO  = 16'd0;
   localparam logic [ANGLE_W-1:0] ANG_HALF  = 16'd16384;
   localparam logic [ANGLE_W-1:0] ANG_PI    = 16'd32768;
   localparam logic [ANGLE_W-1:0] ANG_3HALF = 16'd49152;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] ref_x;
      logic signed [COORD_WIDTH-1:0] ref_y;
      logic signed [COORD_WIDTH-1:0] other_x;
      logic signed [COORD_WIDTH-1:0] other_y;
   } pad_req_type;

   typedef struct packed {
      logic [ANGLE_W-1:0] angle;
      logic [DIST_W-1:0]  dist_res;
      logic               near;
   } pad_rsp_type;

   // side info carried alongside the CORDIC datapath
   typedef struct packed {
      logic               special;
      logic [ANGLE_W-1:0] sp_angle;
      logic [DIST_W-1:0]  sp_dist;
      logic               dx_neg;
      logic               dy_neg;
   } pad_side_type;

   // atan(2^-i), 2^32 = 2pi
   function automatic logic [ZW-1:0] atan_lut(input logic [4:0] idx);
      logic [ZW-1:0] v;
      case (idx)
         5'd0:  v = 32'd536870912;
         5'd1:  v = 32'd316933406;
         5'd2:  v = 32'd167458907;
         5'd3:  v = 32'd85004756;
         5'd4:  v = 32'd42667331;
         5'd5:  v = 32'd21354465;
         5'd6:  v = 32'd10679838;
         5'd7:  v = 32'd5340245;
         5'd8:  v = 32'd2670163;
         5'd9:  v = 32'd1335087;
         5'd10: v = 32'd667544;
         5'd11: v = 32'd333772;
         5'd12: v = 32'd166886;
         5'd13: v = 32'd83443;
         5'd14: v = 32'd41722;
         5'd15: v = 32'd20861;
         5'd16: v = 32'd10430;
         5'd17: v = 32'd5215;
         5'd18: v = 32'd2608;
         5'd19: v = 32'd1304;
         5'd20: v = 32'd652;
         5'd21: v = 32'd326;
         5'd22: v = 32'd163;
         5'd23: v = 32'd81;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pad_cordic_stage.sv
// One registered CORDIC vectoring iteration with its valid bit and side info.
// Depends on pad_pkg.
`timescale 1ns / 1ps
`default_nettype none

module pad_cordic_stage #(
   parameter int STAGE = 0
) (
   input  wire                             clock,
   input  wire                             reset,
   input  wire                             valid_in,
   input  wire logic signed [pad_pkg::XW-1:0] x_in,
   input  wire logic signed [pad_pkg::XW-1:0] y_in,
   input  wire logic signed [pad_pkg::ZW-1:0] z_in,
   input  wire pad_pkg::pad_side_type      side_in,
   output logic                            valid_out,
   output logic signed [pad_pkg::XW-1:0]   x_out,
   output logic signed [pad_pkg::XW-1:0]   y_out,
   output logic signed [pad_pkg::ZW-1:0]   z_out,
   output pad_pkg::pad_side_type           side_out
);
   import pad_pkg::*;

   localparam logic [ZW-1:0] ATAN_STEP = atan_lut(5'(STAGE));

   logic                 valid_ff;
   logic signed [XW-1:0] x_ff, y_ff, x_nx_in, y_nx_in;
   logic signed [ZW-1:0] z_ff, z_nx_in;
   pad_side_type         side_ff;
   logic signed [XW-1:0] xs, ys;

   always_comb begin
      xs = x_in >>> STAGE;
      ys = y_in >>> STAGE;
      if (!y_in[XW-1]) begin
         x_nx_in = x_in + ys;
         y_nx_in = y_in - xs;
         z_nx_in = z_in + $signed(ATAN_STEP);
      end else begin
         x_nx_in = x_in - ys;
         y_nx_in = y_in + xs;
         z_nx_in = z_in - $signed(ATAN_STEP);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff    <= x_nx_in;
      y_ff    <= y_nx_in;
      z_ff    <= z_nx_in;
      side_ff <= side_in;
   end

   assign valid_out = valid_ff;
   assign x_out     = x_ff;
   assign y_out     = y_ff;
   assign z_out     = z_ff;
   assign side_out  = side_ff;

endmodule

`default_nettype wire

// File: hw/rtl/point_angle_and_distance_core.sv
// Point angle and distance core: top level.
// Depends on pad_pkg and pad_cordic_stage.
//
// Usage:
//   Input items (two points, signed Q11.4) arrive on req_item and are taken at
//   every clock edge where start is high; busy is always low, so one item may
//   enter each cycle.
//   Results (angle as a 16-bit binary angle, distance in Q13.4, near flag)
//   appear on rsp_item for one cycle with rsp_strobe high.
//   Throughput is one item per cycle; each item passes in order through the
//   difference and setup registers, one register per CORDIC iteration, the
//   clamp/multiply and quadrant map/rounding registers and the output
//   register.
//   The receiver cannot stall; results are never held.
//   Configuration: near_tolerance is written through csr_valid/csr_wdata,
//   csr_ready is always high. Write it only while no items are in flight.
//   Reset (synchronous) empties the pipeline and sets the tolerance to 160.
`timescale 1ns / 1ps
`default_nettype none

module point_angle_and_distance_core #(
   parameter int CORDIC_STAGES = pad_pkg::DEF_CORDIC_STAGES
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        start,
   output logic                       busy,
   input  wire pad_pkg::pad_req_type  req_item,
   input  wire                        csr_valid,
   output logic                       csr_ready,
   input  wire logic [pad_pkg::TOL_W-1:0] csr_wdata,
   output logic                       rsp_strobe,
   output pad_pkg::pad_rsp_type       rsp_item
);
   import pad_pkg::*;

   localparam int LATENCY = CORDIC_STAGES + 5;

   logic [TOL_W-1:0] tol_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= TOL_RESET;
      end else if (csr_valid && csr_ready) begin
         tol_ff <= csr_wdata;
      end
   end

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // difference stage
   logic                         d_valid_ff;
   logic signed [DIFF_WIDTH-1:0] dx_ff, dy_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         d_valid_ff <= 1'b0;
      end else begin
         d_valid_ff <= start && !busy;
      end
   end

   always_ff @(posedge clock) begin
      dx_ff <= DIFF_WIDTH'(req_item.other_x) - DIFF_WIDTH'(req_item.ref_x);
      dy_ff <= DIFF_WIDTH'(req_item.other_y) - DIFF_WIDTH'(req_item.ref_y);
   end

   // setup stage
   logic [DIFF_WIDTH-1:0] ax, ay;
   logic signed [XW-1:0]  x0_in, y0_in;
   pad_side_type          side0_in;

   always_comb begin
      ax = dx_ff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dx_ff) : DIFF_WIDTH'(dx_ff);
      ay = dy_ff[DIFF_WIDTH-1] ? DIFF_WIDTH'(-dy_ff) : DIFF_WIDTH'(dy_ff);
      x0_in = XW'({ax[COORD_WIDTH-1:0], {GUARD_BITS{1'b0}}});
      y0_in = XW'({ay[COORD_WIDTH-1:0], {GUARD_BITS{1'b0}}});
      side0_in.dx_neg = dx_ff[DIFF_WIDTH-1];
      side0_in.dy_neg = dy_ff[DIFF_WIDTH-1];
      if (dy_ff == '0) begin
         side0_in.special  = 1'b1;
         side0_in.sp_angle = dx_ff[DIFF_WIDTH-1] ? ANG_PI : ANG_ZERO;
         side0_in.sp_dist  = ax;
      end else if (dx_ff == '0) begin
         side0_in.special  = 1'b1;
         side0_in.sp_angle = dy_ff[DIFF_WIDTH-1] ? ANG_3HALF : ANG_HALF;
         side0_in.sp_dist  = ay;
      end else begin
         side0_in.special  = 1'b0;
         side0_in.sp_angle = ANG_ZERO;
         side0_in.sp_dist  = '0;
      end
   end

   logic                 cv   [0:CORDIC_STAGES];
   logic signed [XW-1:0] cx   [0:CORDIC_STAGES];
   logic signed [XW-1:0] cy   [0:CORDIC_STAGES];
   logic signed [ZW-1:0] cz   [0:CORDIC_STAGES];
   pad_side_type         cs   [0:CORDIC_STAGES];

   always_ff @(posedge clock) begin
      if (reset) begin
         cv[0] <= 1'b0;
      end else begin
         cv[0] <= d_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      cx[0] <= x0_in;
      cy[0] <= y0_in;
      cz[0] <= '0;
      cs[0] <= side0_in;
   end

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      pad_cordic_stage #(
         .STAGE(i)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .valid_in (cv[i]),
         .x_in     (cx[i]),
         .y_in     (cy[i]),
         .z_in     (cz[i]),
         .side_in  (cs[i]),
         .valid_out(cv[i+1]),
         .x_out    (cx[i+1]),
         .y_out    (cy[i+1]),
         .z_out    (cz[i+1]),
         .side_out (cs[i+1])
      );
   end

   // clamp and gain-correction multiply
   logic              p1_valid_ff;
   logic [ZZW-1:0]    zc_ff, zc_in;
   logic [PW-1:0]     prod_ff;
   pad_side_type      p1_side_ff;
   logic signed [ZW-1:0] z_last;

   always_comb begin
      z_last = cz[CORDIC_STAGES];
      if (z_last[ZW-1]) begin
         zc_in = '0;
      end else if (ZZW'(z_last) > Z_QUARTER) begin
         zc_in = Z_QUARTER;
      end else begin
         zc_in = ZZW'(z_last);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff <= cv[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      zc_ff      <= zc_in;
      prod_ff    <= PW'(cx[CORDIC_STAGES][XW-2:0]) * PW'(INV_GAIN);
      p1_side_ff <= cs[CORDIC_STAGES];
   end

   // quadrant map, rounding, saturation
   logic                  p2_valid_ff;
   logic [ANGLE_W-1:0]    p2_angle_ff, p2_angle_in;
   logic [DIST_W-1:0]     p2_dist_ff, p2_dist_in;
   logic [ZZW-1:0]        zz, zr;
   logic [PW-1:0]         dsum;
   logic [DIST_RAW_W-1:0] draw;

   always_comb begin
      case ({p1_side_ff.dx_neg, p1_side_ff.dy_neg})
         2'b00:   zz = zc_ff;
         2'b10:   zz = (Z_QUARTER << 1) - zc_ff;
         2'b11:   zz = (Z_QUARTER << 1) + zc_ff;
         default: zz = (Z_QUARTER << 2) - zc_ff;
      endcase
      zr   = zz + ANGLE_ROUND;
      dsum = prod_ff + DIST_ROUND;
      draw = dsum[PW-1:40];
      if (p1_side_ff.special) begin
         p2_angle_in = p1_side_ff.sp_angle;
         p2_dist_in  = p1_side_ff.sp_dist;
      end else begin
         p2_angle_in = zr[31:16];
         p2_dist_in  = (draw > DIST_RAW_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(draw);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p2_valid_ff <= 1'b0;
      end else begin
         p2_valid_ff <= p1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p2_angle_ff <= p2_angle_in;
      p2_dist_ff  <= p2_dist_in;
   end

   // output register
   logic        rsp_strobe_ff;
   pad_rsp_type rsp_item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      rsp_item_ff.angle    <= p2_angle_ff;
      rsp_item_ff.dist_res <= p2_dist_ff;
      rsp_item_ff.near     <= (p2_dist_ff < DIST_W'(tol_ff));
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

   // every result traces back to an accepted item
   a_rsp_has_item: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LATENCY))
      else $error("result without matching item");

   // zero distance only for identical points, which give angle zero
   a_zero_dist_angle: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.dist_res == '0) |-> (rsp_item.angle == ANG_ZERO))
      else $error("zero distance with nonzero angle");

   // a clamped CORDIC angle stays within its quadrant
   a_clamp_range: assert property (@(posedge clock) disable iff (reset)
      p1_valid_ff |-> (zc_ff <= Z_QUARTER))
      else $error("angle accumulator out of range");

endmodule

`default_nettype wire

// File: sim/tb.sv
// Self-checking testbench for point_angle_and_distance_core.
// Streams point pairs, predicts angle, distance and near flag with a
// bit-accurate CORDIC model; depends on pad_pkg and the core RTL.
`timescale 1ns / 1ps

module tb;
   import pad_pkg::*;

   localparam int     STAGES       = DEF_CORDIC_STAGES;
   localparam int     LATENCY      = STAGES + 5;
   localparam int     GUARD        = 8;
   localparam longint QUARTER_TURN = 64'sd1073741824;
   localparam longint INV_K_Q32    = 64'sd2608131496;
   localparam longint RANGE_MAX    = 64'sd131071;
   localparam int     PHASES       = 7;
   localparam int     PHASE_ITEMS  = 268;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   pad_req_type req_item = '0;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [TOL_W-1:0] csr_wdata = '0;
   logic        rsp_strobe;
   pad_rsp_type rsp_item;

   // atan(2^-i), 2^32 = full turn
   longint atan_step [0:15] = '{
      64'sd536870912, 64'sd316933406, 64'sd167458907, 64'sd85004756,
      64'sd42667331,  64'sd21354465,  64'sd10679838,  64'sd5340245,
      64'sd2670163,   64'sd1335087,   64'sd667544,    64'sd333772,
      64'sd166886,    64'sd83443,     64'sd41722,     64'sd20861
   };

   pad_req_type      pending_items[$];
   pad_rsp_type      point_results_due[$];
   pad_rsp_type      due_result;
   logic [TOL_W-1:0] tol_setting = TOL_RESET;
   int               error_count = 0;
   int               burst_left = 0;
   int               gap_left = 0;

   point_angle_and_distance_core uut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_wdata  (csr_wdata),
      .rsp_strobe (rsp_strobe),
      .rsp_item   (rsp_item)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   function automatic pad_rsp_type compute_bearing(input pad_req_type it,
                                                   input logic [TOL_W-1:0] tol);
      longint dx, dy, ax, ay, x, y, z, xs, ys, zz, range_q4;
      pad_rsp_type r;
      dx = longint'($signed(it.other_x)) - longint'($signed(it.ref_x));
      dy = longint'($signed(it.other_y)) - longint'($signed(it.ref_y));
      ax = (dx < 0) ? -dx : dx;
      ay = (dy < 0) ? -dy : dy;
      if (dy == 0) begin
         r.angle = (dx >= 0) ? ANG_ZERO : ANG_PI;
         range_q4 = ax;
      end else if (dx == 0) begin
         r.angle = (dy > 0) ? ANG_HALF : ANG_3HALF;
         range_q4 = ay;
      end else begin
         x = ax <<< GUARD;
         y = ay <<< GUARD;
         z = 0;
         for (int i = 0; i < STAGES; i++) begin
            xs = x >>> i;
            ys = y >>> i;
            if (y >= 0) begin
               x = x + ys;
               y = y - xs;
               z = z + atan_step[i];
            end else begin
               x = x - ys;
               y = y + xs;
               z = z - atan_step[i];
            end
         end
         if (z < 0) z = 0;
         if (z > QUARTER_TURN) z = QUARTER_TURN;
         if (dx > 0 && dy > 0) zz = z;
         else if (dx < 0 && dy > 0) zz = 2 * QUARTER_TURN - z;
         else if (dx < 0) zz = 2 * QUARTER_TURN + z;
         else zz = 4 * QUARTER_TURN - z;
         r.angle = ANGLE_W'((zz + 64'sd32768) >>> 16);
         if (x >= (64'sd1 <<< 27)) range_q4 = RANGE_MAX;
         else range_q4 = (x * INV_K_Q32 + (64'sd1 <<< 39)) >>> 40;
      end
      if (range_q4 > RANGE_MAX) range_q4 = RANGE_MAX;
      r.dist_res = DIST_W'(range_q4);
      r.near = (range_q4 < longint'(tol));
      return r;
   endfunction

   function automatic logic [COORD_WIDTH-1:0] offset_coord(input int base, input int span);
      int v;
      v = base + int'($urandom_range(0, 2 * span)) - span;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
      return COORD_WIDTH'(v);
   endfunction

   function automatic logic [COORD_WIDTH-1:0] edge_coord();
      case ($urandom_range(0, 4))
         0: return 16'h8000;
         1: return 16'h7FFF;
         2: return 16'h0000;
         3: return 16'hFFFF;
         default: return COORD_WIDTH'($urandom);
      endcase
   endfunction

   function automatic pad_req_type random_point_pair();
      pad_req_type it;
      int span;
      it.ref_x   = COORD_WIDTH'($urandom);
      it.ref_y   = COORD_WIDTH'($urandom);
      it.other_x = COORD_WIDTH'($urandom);
      it.other_y = COORD_WIDTH'($urandom);
      span = 1 << $urandom_range(0, 12);
      case ($urandom_range(0, 9))
         4, 5, 6: begin
            it.other_x = offset_coord(it.ref_x, span);
            it.other_y = offset_coord(it.ref_y, span);
         end
         7: it.other_y = ($urandom_range(0, 1)) ? it.ref_y : offset_coord(it.ref_y, 1);
         8: it.other_x = ($urandom_range(0, 1)) ? it.ref_x : offset_coord(it.ref_x, 1);
         9: begin
            if ($urandom_range(0, 1)) begin
               it.other_x = it.ref_x;
               it.other_y = it.ref_y;
            end else begin
               it.ref_x   = edge_coord();
               it.ref_y   = edge_coord();
               it.other_x = edge_coord();
               it.other_y = edge_coord();
            end
         end
         default: ;
      endcase
      return it;
   endfunction

   task automatic add_pair(input int rx, input int ry, input int ox, input int oy);
      pad_req_type it;
      it.ref_x   = COORD_WIDTH'(rx);
      it.ref_y   = COORD_WIDTH'(ry);
      it.other_x = COORD_WIDTH'(ox);
      it.other_y = COORD_WIDTH'(oy);
      pending_items.push_back(it);
   endtask

   task automatic wait_for_drain();
      while (pending_items.size() != 0 || start || point_results_due.size() != 0)
         @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_tolerance(input logic [TOL_W-1:0] v);
      csr_valid <= 1'b1;
      csr_wdata <= v;
      do @(posedge clock); while (!csr_ready);
      tol_setting = v;
      csr_valid <= 1'b0;
   endtask

   // driver: bursts of items separated by random gaps
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         burst_left = 0;
         gap_left = 0;
      end else begin
         if (start && !busy)
            point_results_due.push_back(compute_bearing(req_item, tol_setting));
         if (!(start && busy)) begin
            if (gap_left > 0) begin
               gap_left--;
               start <= 1'b0;
            end else if (pending_items.size() == 0) begin
               start <= 1'b0;
            end else begin
               start <= 1'b1;
               req_item <= pending_items.pop_front();
               if (burst_left > 0) begin
                  burst_left--;
               end else begin
                  burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(100, 300)
                                                           : $urandom_range(0, 40);
                  gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
               end
            end
         end
      end
   end

   // monitor
   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (point_results_due.size() == 0) begin
            $error("unexpected result: angle %0d dist_res %0d near %0d",
                   rsp_item.angle, rsp_item.dist_res, rsp_item.near);
            error_count++;
         end else begin
            due_result = point_results_due.pop_front();
            if (rsp_item.angle !== due_result.angle) begin
               $error("angle: expected %0d, got %0d", due_result.angle, rsp_item.angle);
               error_count++;
            end
            if (rsp_item.dist_res !== due_result.dist_res) begin
               $error("dist_res: expected %0d, got %0d",
                      due_result.dist_res, rsp_item.dist_res);
               error_count++;
            end
            if (rsp_item.near !== due_result.near) begin
               $error("near: expected %0d, got %0d", due_result.near, rsp_item.near);
               error_count++;
            end
         end
      end
   end

   initial begin
      logic [TOL_W-1:0] tol_plan [PHASES];
      tol_plan[0] = TOL_RESET;
      tol_plan[1] = 16'd0;
      tol_plan[2] = 16'hFFFF;
      tol_plan[3] = TOL_W'($urandom_range(1, 400));
      tol_plan[4] = TOL_W'($urandom);
      tol_plan[5] = 16'd1;
      tol_plan[6] = TOL_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      for (int ph = 0; ph < PHASES; ph++) begin
         if (ph > 0) write_tolerance(tol_plan[ph]);
         if (ph == 0) begin
            add_pair(0, 0, 0, 0);
            add_pair(-32768, 32767, -32768, 32767);
            add_pair(0, 0, 100, 0);
            add_pair(0, 0, -100, 0);
            add_pair(5, 5, 5, 32767);
            add_pair(5, 5, 5, -32768);
            add_pair(0, 0, 48, 64);
            add_pair(0, 0, -48, 64);
            add_pair(0, 0, -48, -64);
            add_pair(0, 0, 48, -64);
            add_pair(10, 10, 1010, 1010);
            add_pair(0, 0, 1, 1);
            add_pair(0, 0, -1, 1);
            add_pair(-32768, -32768, 32767, 32767);
            add_pair(32767, 32767, -32768, -32768);
            add_pair(32767, -32768, -32768, 32767);
            add_pair(-32768, 32767, 32767, -32768);
            add_pair(0, 0, 159, 0);
            add_pair(0, 0, 160, 0);
            add_pair(0, 0, -160, 0);
            add_pair(0, 0, 113, 113);
            add_pair(0, 0, 1, 32767);
            add_pair(0, 0, 32767, 1);
            add_pair(0, 0, 32767, -1);
            add_pair(0, 0, -1, -32768);
         end else begin
            add_pair(7, 7, 7, 7);
            add_pair(0, 0, 1, 0);
            add_pair(-3, 2, -2, 3);
         end
         repeat (PHASE_ITEMS) pending_items.push_back(random_point_pair());
         wait_for_drain();
      end
      repeat (2 * LATENCY) @(posedge clock);
      if (point_results_due.size() != 0) begin
         $error("%0d results never arrived", point_results_due.size());
         error_count++;
      end
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("DONE: errors detected");
      $finish;
   end

endmodule
